// ===== rtl/i2cms_pkg.sv =====
// Shared types and constants for the I2C master bit sequencer.
// No dependencies; imported by the top level and by i2cms_step.
package i2cms_pkg;

  localparam int unsigned BYTE_BITS = 8;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  // Register byte offsets on the configuration port
  localparam logic [2:0] REG_ACK_TIMEOUT = 3'd0;

  // Active command, also the opcode encoding on the input channel
  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_WAIT  = 3'd5
  } cmd_t;

  // Sequencer state carried from tick to tick
  typedef struct packed {
    cmd_t       cmd;
    logic [2:0] phase;
    logic [3:0] bit_idx;
    logic [7:0] shift;
    logic [7:0] wait_cnt;
    logic       ack_choice;
    logic       scl;
    logic       drv;
    logic       lvl;
  } seq_state_t;

  // One result transaction
  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_level;
    logic       busy_res;
    logic [7:0] read_data;
    logic       read_valid;
    logic       ack_error;
    logic       done_res;
  } seq_result_t;

  localparam seq_state_t SEQ_STATE_RST = '{
    cmd: CMD_IDLE, phase: 3'd0, bit_idx: 4'd0, shift: 8'd0, wait_cnt: 8'd0,
    ack_choice: 1'b0, scl: 1'b1, drv: 1'b1, lvl: 1'b1
  };

endpackage

// ===== rtl/i2c_master_bit_sequencer_top.sv =====
// I2C master bit sequencer: top level with handshakes, register port and state.
// Depends on i2cms_pkg and i2cms_step.
//
// Each input transaction is one half-bit tick from an external prescaler, carrying
// the sampled SDA level and, while the sequencer is idle, a command (start, stop,
// write byte MSB first, read byte with ACK/NACK, wait for ACK). Every accepted tick
// produces exactly one result transaction with the SCL level, SDA drive and level,
// busy, the read byte with its strobe, the ACK timeout error and a done pulse.
// Commands arriving while busy are ignored, as are opcodes 6 and 7. The sequencer
// state advances in a single pass of logic at the input handshake, and the result
// is registered in an output register, so a tick can be accepted every clock as
// long as the result side keeps up. The input is stalled only while the output
// register is full and stalled itself. The register ack_timeout (byte offset 0,
// reset 250) sets how many high SDA polls are tolerated during wait-for-ACK; the
// next high poll starts a stop and flags ack_error on its last tick. Write the
// register only while no tick is in flight.
module i2c_master_bit_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_write_data,
  input  logic        in_send_ack,
  input  logic        in_sda_sample,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_level,
  output logic        out_sda_drive,
  output logic        out_sda_level,
  output logic        out_busy_res,
  output logic [7:0]  out_read_data,
  output logic        out_read_valid,
  output logic        out_ack_error,
  output logic        out_done_res,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2cms_pkg::*;

  seq_state_t  state_r;
  seq_state_t  state_nxt;
  seq_result_t result_nxt;
  seq_result_t result_r;
  logic        out_valid_r;
  logic [7:0]  ack_timeout_r;
  logic        in_fire;
  logic        cfg_wr;

  // Accept a tick whenever the output register is free or drains this cycle
  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  // Register port: no wait states, one register at offset 0
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr == REG_ACK_TIMEOUT) ? {24'd0, ack_timeout_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_wr && paddr == REG_ACK_TIMEOUT) begin
      ack_timeout_r <= pwdata[7:0];
    end
  end

  i2cms_step u_step (
    .state_i       (state_r),
    .opcode_i      (in_opcode),
    .write_data_i  (in_write_data),
    .send_ack_i    (in_send_ack),
    .sda_sample_i  (in_sda_sample),
    .ack_timeout_i (ack_timeout_r),
    .state_nxt_o   (state_nxt),
    .result_o      (result_nxt)
  );

  // Advance the sequencer one phase per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_STATE_RST;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Output register: load on accept, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scl_level  = result_r.scl_level;
  assign out_sda_drive  = result_r.sda_drive;
  assign out_sda_level  = result_r.sda_level;
  assign out_busy_res   = result_r.busy_res;
  assign out_read_data  = result_r.read_data;
  assign out_read_valid = result_r.read_valid;
  assign out_ack_error  = result_r.ack_error;
  assign out_done_res   = result_r.done_res;

endmodule

// ===== rtl/i2cms_step.sv =====
// Next-state and result logic for one half-bit tick of the sequencer.
// Depends on i2cms_pkg.
module i2cms_step (
  input  i2cms_pkg::seq_state_t  state_i,
  input  logic [2:0]             opcode_i,
  input  logic [7:0]             write_data_i,
  input  logic                   send_ack_i,
  input  logic                   sda_sample_i,
  input  logic [7:0]             ack_timeout_i,
  output i2cms_pkg::seq_state_t  state_nxt_o,
  output i2cms_pkg::seq_result_t result_o
);
  import i2cms_pkg::*;

  seq_state_t cur;
  seq_state_t nxt;
  logic [3:0] bit_inc;
  logic       rd_valid;
  logic       err;
  logic       done;

  // Next state: take a command when idle, then run this tick's phase
  always_comb begin
    cur = state_i;
    if (state_i.cmd == CMD_IDLE && opcode_i >= CMD_START && opcode_i <= CMD_WAIT) begin
      cur.cmd     = cmd_t'(opcode_i);
      cur.phase   = 3'd0;
      cur.bit_idx = 4'd0;
      unique case (cmd_t'(opcode_i))
        CMD_WRITE: cur.shift = write_data_i;
        CMD_READ: begin
          cur.shift      = 8'd0;
          cur.ack_choice = send_ack_i;
        end
        CMD_WAIT: cur.wait_cnt   = 8'd0;
        CMD_STOP: cur.ack_choice = 1'b0;
        default: ;
      endcase
    end

    nxt      = cur;
    bit_inc  = cur.bit_idx + 4'd1;
    rd_valid = 1'b0;
    err      = 1'b0;
    done     = 1'b0;

    unique case (cur.cmd)
      CMD_IDLE: ;
      CMD_START: begin
        unique case (cur.phase)
          3'd0: begin
            nxt.scl = 1'b1; nxt.drv = 1'b1; nxt.lvl = 1'b1; nxt.phase = 3'd1;
          end
          3'd1: begin
            nxt.lvl = 1'b0; nxt.phase = 3'd2;
          end
          3'd2: begin
            nxt.scl = 1'b0; nxt.cmd = CMD_IDLE; nxt.phase = 3'd0; done = 1'b1;
          end
          default: begin
            nxt.cmd = CMD_IDLE; nxt.phase = 3'd0;
          end
        endcase
      end
      CMD_STOP: begin
        unique case (cur.phase)
          3'd0: begin
            nxt.scl = 1'b0; nxt.drv = 1'b1; nxt.lvl = 1'b0; nxt.phase = 3'd1;
          end
          3'd1: begin
            nxt.scl = 1'b1; nxt.phase = 3'd2;
          end
          3'd2: begin
            nxt.lvl = 1'b1; nxt.drv = 1'b1; err = cur.ack_choice;
            nxt.cmd = CMD_IDLE; nxt.phase = 3'd0; done = 1'b1;
          end
          default: begin
            nxt.cmd = CMD_IDLE; nxt.phase = 3'd0;
          end
        endcase
      end
      CMD_WRITE: begin
        unique case (cur.phase)
          3'd0: begin
            nxt.scl = 1'b0; nxt.drv = 1'b1; nxt.lvl = cur.shift[7]; nxt.phase = 3'd1;
          end
          3'd1: begin
            nxt.scl     = 1'b1;
            nxt.shift   = {cur.shift[6:0], 1'b0};
            nxt.bit_idx = bit_inc;
            nxt.phase   = (32'(bit_inc) >= BYTE_BITS) ? 3'd2 : 3'd0;
          end
          3'd2: begin
            nxt.scl = 1'b0; nxt.cmd = CMD_IDLE; nxt.phase = 3'd0; done = 1'b1;
          end
          default: begin
            nxt.cmd = CMD_IDLE; nxt.phase = 3'd0;
          end
        endcase
      end
      CMD_READ: begin
        unique case (cur.phase)
          3'd0: begin
            nxt.scl = 1'b0; nxt.drv = 1'b0; nxt.lvl = 1'b1; nxt.phase = 3'd1;
          end
          3'd1: begin
            nxt.scl     = 1'b1;
            nxt.shift   = {cur.shift[6:0], sda_sample_i};
            nxt.bit_idx = bit_inc;
            nxt.phase   = (32'(bit_inc) >= BYTE_BITS) ? 3'd2 : 3'd0;
          end
          3'd2: begin
            // ACK pulls SDA low, NACK releases it high
            nxt.scl   = 1'b0;
            nxt.drv   = cur.ack_choice;
            nxt.lvl   = ~cur.ack_choice;
            nxt.phase = 3'd3;
          end
          3'd3: begin
            nxt.scl = 1'b1; nxt.phase = 3'd4;
          end
          3'd4: begin
            nxt.scl = 1'b0; rd_valid = 1'b1;
            nxt.cmd = CMD_IDLE; nxt.phase = 3'd0; done = 1'b1;
          end
          default: begin
            nxt.cmd = CMD_IDLE; nxt.phase = 3'd0;
          end
        endcase
      end
      CMD_WAIT: begin
        unique case (cur.phase)
          3'd0: begin
            nxt.scl = 1'b0; nxt.drv = 1'b0; nxt.lvl = 1'b1; nxt.phase = 3'd1;
          end
          3'd1: begin
            nxt.scl = 1'b1; nxt.phase = 3'd2;
          end
          3'd2: begin
            priority if (!sda_sample_i) begin
              nxt.scl = 1'b0; nxt.cmd = CMD_IDLE; nxt.phase = 3'd0; done = 1'b1;
            end else if (cur.wait_cnt >= ack_timeout_i) begin
              // Timeout: begin the stop sequence on this same tick
              nxt.cmd        = CMD_STOP;
              nxt.ack_choice = 1'b1;
              nxt.scl        = 1'b0;
              nxt.drv        = 1'b1;
              nxt.lvl        = 1'b0;
              nxt.phase      = 3'd1;
            end else begin
              nxt.wait_cnt = cur.wait_cnt + 8'd1;
            end
          end
          default: begin
            nxt.cmd = CMD_IDLE; nxt.phase = 3'd0;
          end
        endcase
      end
      default: begin
        nxt.cmd = CMD_IDLE; nxt.phase = 3'd0;
      end
    endcase
  end

  // Result fields from the line state after this tick
  always_comb begin
    result_o.scl_level  = nxt.scl;
    result_o.sda_drive  = nxt.drv;
    result_o.sda_level  = nxt.drv ? nxt.lvl : 1'b1;
    result_o.busy_res   = (nxt.cmd != CMD_IDLE);
    result_o.read_data  = rd_valid ? nxt.shift : 8'd0;
    result_o.read_valid = rd_valid;
    result_o.ack_error  = err;
    result_o.done_res   = done;
  end

  assign state_nxt_o = nxt;

endmodule

// ===== rtl/i2cms_checker.sv =====
// Port-level checks for the I2C master bit sequencer, bound to the top level.
// Depends on the top level's port list only.
module i2cms_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_scl_level,
  input logic       out_sda_drive,
  input logic       out_sda_level,
  input logic       out_busy_res,
  input logic [7:0] out_read_data,
  input logic       out_read_valid,
  input logic       out_ack_error,
  input logic       out_done_res
);

  // A finished read ends the command with SCL low
  a_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_valid |-> out_done_res && !out_busy_res && !out_scl_level)
    else $error("read strobe without command completion");

  // A timeout error ends a stop: both lines high, not a read
  a_err_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ack_error |->
      out_done_res && !out_read_valid && out_scl_level && out_sda_level)
    else $error("ack error outside the end of a stop");

  // Read data is zero except on the read strobe
  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_valid |-> out_read_data == 8'd0)
    else $error("read data nonzero without strobe");

  // A released SDA line reads as high
  a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sda_drive |-> out_sda_level)
    else $error("released SDA reported low");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) && $stable(out_done_res))
    else $error("stalled result changed");

endmodule

bind i2c_master_bit_sequencer_top i2cms_checker u_i2cms_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_scl_level  (out_scl_level),
  .out_sda_drive  (out_sda_drive),
  .out_sda_level  (out_sda_level),
  .out_busy_res   (out_busy_res),
  .out_read_data  (out_read_data),
  .out_read_valid (out_read_valid),
  .out_ack_error  (out_ack_error),
  .out_done_res   (out_done_res)
);
